### rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types, codes and defaults for the sequencer track unit.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int MAX_EVENTS_DEF = 64;
  localparam int POS_BITS       = 16;
  localparam int ROW_BITS       = 12;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_SET    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  localparam logic [1:0] KIND_MUTE    = 2'd0;
  localparam logic [1:0] KIND_BREAK   = 2'd1;
  localparam logic [1:0] KIND_BYPASS  = 2'd2;
  localparam logic [1:0] KIND_PATTERN = 2'd3;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_MUTE    = 3'd1;
  localparam logic [2:0] ACT_CLEAR   = 3'd2;
  localparam logic [2:0] ACT_BYPASS  = 3'd3;
  localparam logic [2:0] ACT_PATTERN = 3'd4;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_MUTED  = 2'd1;
  localparam logic [1:0] MODE_BYPASS = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // slot memory read address select
  localparam logic [1:0] RD_IDX   = 2'd0;  // scan index
  localparam logic [1:0] RD_BELOW = 2'd1;  // move pointer - 1
  localparam logic [1:0] RD_ABOVE = 2'd2;  // move pointer + 1

  typedef struct packed {
    logic [1:0]          func;
    logic [POS_BITS-1:0] event_position;
    logic [1:0]          event_kind;
    logic [7:0]          pattern_id;
    logic [ROW_BITS-1:0] pattern_length;
    logic                play_enabled;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          action;
    logic [1:0]          machine_mode;
    logic                row_play;
    logic [7:0]          row_pattern;
    logic [ROW_BITS-1:0] row_index;
    logic [1:0]          status;
    logic [POS_BITS-1:0] current_position;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       latch;      // capture input item, clear scan index
    logic       rd;         // issue memory read
    logic [1:0] rd_sel;     // read address select
    logic       step;       // scan index +1
    logic       ins_start;  // move pointer <- count
    logic       rem_start;  // move pointer <- scan index
    logic       wr_move;    // write read data at move pointer
    logic       mv_dn;
    logic       mv_up;
    logic       wr_new;     // write new event at scan index
    logic       tick_apply; // apply tick
    logic       cnt_inc;
    logic       cnt_dec;
    logic       load_out;
    logic [1:0] st;
  } tes_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] func;
    logic at_end;     // idx == count
    logic less;       // read slot position < key
    logic equal;      // read slot position == key
    logic full;
    logic mv_at_idx;  // move pointer == idx
    logic mv_last;    // move pointer + 1 == count
  } tes_sts_t;

endpackage

### rtl/tes_datapath.sv
// ----------------------------------------------------------------------------
// tes_datapath
// Slot memory, scan and move pointers, track and pattern registers, output
// register.
// ----------------------------------------------------------------------------
module tes_datapath #(
  parameter int MAX_EVENTS = tes_pkg::MAX_EVENTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tes_pkg::in_item_t   in_item,
  input  tes_pkg::tes_cmd_t   cmd,
  output tes_pkg::tes_sts_t   sts,
  output tes_pkg::out_item_t  out_item
);

  localparam int IW = $clog2(MAX_EVENTS);
  localparam int CW = $clog2(MAX_EVENTS + 1);
  localparam int PB = tes_pkg::POS_BITS;
  localparam int RB = tes_pkg::ROW_BITS;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  typedef struct packed {
    logic [PB-1:0] pos;
    logic [1:0]    kind;
    logic [7:0]    pat;
    logic [RB-1:0] len;
  } slot_t;

  slot_t mem [MAX_EVENTS];
  slot_t rdata;
  slot_t new_slot;
  slot_t wdata;
  tes_pkg::in_item_t item;
  logic [CW-1:0] idx;
  logic [CW-1:0] mv;
  logic [CW-1:0] count;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic [PB-1:0] key;
  logic [PB-1:0] track_position;
  logic          active_valid;
  logic          active_valid_next;
  logic [7:0]    active_pattern;
  logic [7:0]    active_pattern_next;
  logic [RB-1:0] active_length;
  logic [RB-1:0] active_length_next;
  logic [RB-1:0] row_counter;
  logic [RB-1:0] row_counter_next;
  logic [RB-1:0] row_base;
  logic [1:0]    mode_reg;
  logic [1:0]    mode_reg_next;
  logic [2:0]    action;
  logic          at_end;
  logic          equal;
  logic          hit;
  logic          row_live;
  logic          play;

  assign key = (item.func == tes_pkg::FUNC_TICK) ? track_position : item.event_position;

  always_comb begin
    unique case (cmd.rd_sel)
      tes_pkg::RD_BELOW: raddr = IW'(mv - CW'(1));
      tes_pkg::RD_ABOVE: raddr = IW'(mv + CW'(1));
      default:           raddr = IW'(idx);
    endcase
  end

  always_comb begin
    new_slot.pos  = item.event_position;
    new_slot.kind = item.event_kind;
    new_slot.pat  = item.pattern_id;
    new_slot.len  = item.pattern_length;
  end

  assign wdata = cmd.wr_move ? rdata : new_slot;
  assign waddr = cmd.wr_move ? IW'(mv) : IW'(idx);

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata <= mem[raddr];
    if (cmd.wr_move || cmd.wr_new) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item <= in_item;
  end

  assign at_end = (idx == count);
  assign equal  = (rdata.pos == key);
  assign hit    = cmd.tick_apply && equal && !at_end;

  // event at the playhead, then the row step of the active pattern
  always_comb begin
    mode_reg_next       = mode_reg;
    active_valid_next   = active_valid;
    active_pattern_next = active_pattern;
    active_length_next  = active_length;
    row_base            = row_counter;
    action              = tes_pkg::ACT_NONE;
    if (hit) begin
      unique case (rdata.kind)
        tes_pkg::KIND_MUTE: begin
          mode_reg_next = tes_pkg::MODE_MUTED; active_valid_next = 1'b0;
          action = tes_pkg::ACT_MUTE;
        end
        tes_pkg::KIND_BREAK: begin
          mode_reg_next = tes_pkg::MODE_NORMAL; active_valid_next = 1'b0;
          action = tes_pkg::ACT_CLEAR;
        end
        tes_pkg::KIND_BYPASS: begin
          mode_reg_next = tes_pkg::MODE_BYPASS; active_valid_next = 1'b0;
          action = tes_pkg::ACT_BYPASS;
        end
        default: begin
          mode_reg_next = tes_pkg::MODE_NORMAL; active_valid_next = 1'b1;
          active_pattern_next = rdata.pat;
          active_length_next  = rdata.len;
          row_base = '0;
          action = tes_pkg::ACT_PATTERN;
        end
      endcase
    end
    row_live = active_valid_next && (row_base < active_length_next);
    row_counter_next = row_live ? row_base + RB'(1) : row_base;
    play = cmd.tick_apply && row_live && item.play_enabled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      mv <= '0;
      count <= '0;
      track_position <= '0;
      active_valid <= 1'b0;
      active_pattern <= '0;
      active_length <= '0;
      row_counter <= '0;
      mode_reg <= tes_pkg::MODE_NORMAL;
    end else begin
      if (cmd.latch) idx <= '0;
      else if (cmd.step) idx <= idx + CW'(1);
      if (cmd.ins_start) mv <= count;
      else if (cmd.rem_start) mv <= idx;
      else if (cmd.mv_dn) mv <= mv - CW'(1);
      else if (cmd.mv_up) mv <= mv + CW'(1);
      if (cmd.cnt_inc) count <= count + CW'(1);
      else if (cmd.cnt_dec) count <= count - CW'(1);
      if (cmd.tick_apply) begin
        mode_reg <= mode_reg_next;
        active_valid <= active_valid_next;
        active_pattern <= active_pattern_next;
        active_length <= active_length_next;
        row_counter <= row_counter_next;
        if (track_position != POS_MAX) track_position <= track_position + PB'(1);
      end
    end
  end

  // output register, position taken before the tick moves it
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item.action <= action;
      out_item.machine_mode <= mode_reg_next;
      out_item.row_play <= play;
      out_item.row_pattern <= play ? active_pattern_next : 8'd0;
      out_item.row_index <= play ? row_base : '0;
      out_item.status <= cmd.st;
      out_item.current_position <= track_position;
    end
  end

  always_comb begin
    sts.func      = item.func;
    sts.at_end    = at_end;
    sts.less      = rdata.pos < key;
    sts.equal     = equal;
    sts.full      = (count == CW'(MAX_EVENTS));
    sts.mv_at_idx = (mv == idx);
    sts.mv_last   = ((mv + CW'(1)) == count);
  end

endmodule

### rtl/tes_ctrl.sv
// ----------------------------------------------------------------------------
// tes_ctrl
// Sequencer for search, insert shift, remove shift and result hand-off.
// ----------------------------------------------------------------------------
module tes_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tes_pkg::tes_sts_t  sts,
  output tes_pkg::tes_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;  // read issued for idx
  localparam logic [2:0] S_CMP    = 3'd2;  // compare read data
  localparam logic [2:0] S_DEC    = 3'd3;  // search done: finish or start a move
  localparam logic [2:0] S_INS    = 3'd4;  // read mv-1 for move up
  localparam logic [2:0] S_INS_WR = 3'd5;
  localparam logic [2:0] S_REM    = 3'd6;  // read mv+1 for move down
  localparam logic [2:0] S_REM_WR = 3'd7;

  logic [2:0] state, state_next;
  logic ovalid, ovalid_next;
  logic out_hold;
  logic hit;

  assign out_valid = ovalid;
  assign in_stall  = (state != S_IDLE);
  assign out_hold  = ovalid && out_stall;
  assign hit       = sts.equal && !sts.at_end;

  always_comb begin
    state_next = state;
    ovalid_next = out_hold;
    cmd = '0;
    cmd.st = tes_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (sts.at_end) begin
          state_next = S_DEC;
        end else begin
          cmd.rd = 1'b1; cmd.rd_sel = tes_pkg::RD_IDX; state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.less) begin
          cmd.step = 1'b1; state_next = S_RD;
        end else begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.func == tes_pkg::FUNC_SET && !hit && !sts.full) begin
          cmd.ins_start = 1'b1; state_next = S_INS;
        end else if (sts.func == tes_pkg::FUNC_REMOVE && hit) begin
          cmd.rem_start = 1'b1; state_next = S_REM;
        end else if (!out_hold) begin
          cmd.load_out = 1'b1; ovalid_next = 1'b1; state_next = S_IDLE;
          unique case (sts.func)
            tes_pkg::FUNC_TICK: cmd.tick_apply = 1'b1;
            tes_pkg::FUNC_SET: begin
              if (hit) cmd.wr_new = 1'b1;
              else cmd.st = tes_pkg::ST_FULL;
            end
            tes_pkg::FUNC_REMOVE: cmd.st = tes_pkg::ST_NOT_FOUND;
            default: ;
          endcase
        end
      end
      S_INS: begin
        if (!sts.mv_at_idx) begin
          cmd.rd = 1'b1; cmd.rd_sel = tes_pkg::RD_BELOW; state_next = S_INS_WR;
        end else if (!out_hold) begin
          cmd.wr_new = 1'b1; cmd.cnt_inc = 1'b1; cmd.load_out = 1'b1;
          ovalid_next = 1'b1; state_next = S_IDLE;
        end
      end
      S_INS_WR: begin
        cmd.wr_move = 1'b1; cmd.mv_dn = 1'b1; state_next = S_INS;
      end
      S_REM: begin
        if (!sts.mv_last) begin
          cmd.rd = 1'b1; cmd.rd_sel = tes_pkg::RD_ABOVE; state_next = S_REM_WR;
        end else if (!out_hold) begin
          cmd.cnt_dec = 1'b1; cmd.load_out = 1'b1;
          ovalid_next = 1'b1; state_next = S_IDLE;
        end
      end
      S_REM_WR: begin
        cmd.wr_move = 1'b1; cmd.mv_up = 1'b1; state_next = S_REM;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      ovalid <= ovalid_next;
    end
  end

endmodule

### rtl/tick_event_sequencer_track_unit.sv
// ----------------------------------------------------------------------------
// tick_event_sequencer_track_unit
// Position-sorted event table with tick playback of patterns.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | tes_pkg::in_item_t
//  out     | output    | out_valid/out_stall| tes_pkg::out_item_t
//
//  One item at a time. The slot memory has one read and one write port; the
//  scan reads slot 0 upward, a read state and a compare state per slot, and
//  stops at the first position not less than the key or at the end of the
//  table. An insert or remove then moves slots one at a time, a read state
//  and a write state per slot moved, and then finishes.
//  Reset (rst, synchronous) empties the table and returns to normal mode.
//  in_stall is high while an item is in work; the finishing cycle waits while
//  the previous result is still stalled in the output register.
// ----------------------------------------------------------------------------
module tick_event_sequencer_track_unit #(
  parameter int MAX_EVENTS = tes_pkg::MAX_EVENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tes_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tes_pkg::out_item_t out_data
);

  tes_pkg::tes_cmd_t cmd;
  tes_pkg::tes_sts_t sts;

  tes_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  tes_datapath #(
    .MAX_EVENTS(MAX_EVENTS)
  ) u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .sts, .out_item(out_data)
  );

endmodule

### rtl/tes_checker.sv
// ----------------------------------------------------------------------------
// tes_checker
// Port-level checks on the track unit.
// ----------------------------------------------------------------------------
module tes_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input tes_pkg::out_item_t out_data
);

  a_row_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.row_play |-> out_data.row_index == '0)
    else $error("row index set without play");

  a_tick_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.action != tes_pkg::ACT_NONE |-> out_data.status == tes_pkg::ST_OK)
    else $error("status on tick");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind tick_event_sequencer_track_unit tes_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
